FILE: sv/dpb_pkg.sv
// dpb_pkg: shared constants, register indexes and pipeline stage types
// for the depth pixel back-projection unit; no dependencies
`default_nettype none

package dpb_pkg;

    localparam int MAX_COLUMNS = 4096;
    localparam int MAX_ROWS    = 4096;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_DEPTH_SCALE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_X     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Y     = 3'd4;

    localparam logic [15:0] CENTER_X_RST        = 16'd5208;
    localparam logic [15:0] CENTER_Y_RST        = 16'd4056;
    localparam logic [23:0] INV_DEPTH_SCALE_RST = 24'd16777;
    localparam logic [23:0] INV_FOCAL_X_RST     = 24'd32389;
    localparam logic [23:0] INV_FOCAL_Y_RST     = 24'd32326;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 120;

    // products after the first multiply
    typedef struct packed {
        logic [39:0] zf;
        logic [39:0] mx;
        logic [39:0] my;
        logic        neg_x;
        logic        neg_y;
        logic [23:0] color;
    } s1_t;

    // rounded depth and lateral scale factors
    typedef struct packed {
        logic [31:0] zr;
        logic [27:0] tx;
        logic [27:0] ty;
        logic        neg_x;
        logic        neg_y;
        logic [23:0] color;
    } s2_t;

    // lateral products before rounding
    typedef struct packed {
        logic [59:0] px;
        logic [59:0] py;
        logic [31:0] zr;
        logic        neg_x;
        logic        neg_y;
        logic [23:0] color;
    } s3_t;

endpackage

`default_nettype wire

FILE: sv/depth_pixel_backprojection_unit.sv
// depth_pixel_backprojection_unit: pinhole back-projection of rgb-d pixels
// into q16.16 points with color; uses dpb_pkg
`default_nettype none

// Takes one pixel word per clock and returns its 3-D point through four
// register stages: three parallel 16x24 multipliers, rounding, two 28x32
// lateral multipliers, then rounding and saturation into the output
// register. Sustained rate is one pixel per cycle; a stall on the output
// holds the pipeline and bubbles are squeezed out. Pixels with zero depth or
// outside the image produce no output word. Configuration writes are taken
// every cycle and must only happen while the pipeline is empty.
module depth_pixel_backprojection_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // column, row, depth_raw, blue_in, green_in, red_in
    input  wire logic [dpb_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // pos_x, pos_y, pos_z, blue_out, green_out, red_out, one zero pad bit
    output logic [dpb_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [dpb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [dpb_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import dpb_pkg::*;

    localparam logic [13:0] COL_LIMIT = 14'(MAX_COLUMNS);
    localparam logic [13:0] ROW_LIMIT = 14'(MAX_ROWS);
    localparam logic [43:0] POS_MAX   = 44'h000_7FFF_FFFF;
    localparam logic [43:0] NEG_MAX   = 44'h000_8000_0000;
    localparam logic [31:0] Z_MAX     = 32'h7FFF_FFFF;

    function automatic logic [31:0] sat_lat(input logic [43:0] mag, input logic neg);
        logic [43:0] clip;
        logic [43:0] twos;
        if (neg)
        begin
            clip = (mag > NEG_MAX) ? NEG_MAX : mag;
            twos = 44'd0 - clip;
            return twos[31:0];
        end
        else
        begin
            clip = (mag > POS_MAX) ? POS_MAX : mag;
            return clip[31:0];
        end
    endfunction

    logic [15:0] center_x_reg;
    logic [15:0] center_y_reg;
    logic [23:0] inv_depth_scale_reg;
    logic [23:0] inv_focal_x_reg;
    logic [23:0] inv_focal_y_reg;

    logic        s1_v_reg;
    logic        s2_v_reg;
    logic        s3_v_reg;
    logic        out_v_reg;
    s1_t         s1_reg;
    s1_t         s1_next;
    s2_t         s2_reg;
    s2_t         s2_next;
    s3_t         s3_reg;
    s3_t         s3_next;
    logic [OUT_DATA_W-1:0] out_reg;
    logic [OUT_DATA_W-1:0] out_next;

    logic        adv1;
    logic        adv2;
    logic        adv3;
    logic        adv4;
    logic        in_accept;
    logic        keep;

    logic [11:0] in_column;
    logic [11:0] in_row;
    logic [15:0] in_depth;
    logic [15:0] px_col;
    logic [15:0] px_row;
    logic [15:0] mag_x;
    logic [15:0] mag_y;
    logic        neg_x;
    logic        neg_y;
    logic [39:0] zf_rnd;
    logic [39:0] mx_rnd;
    logic [39:0] my_rnd;
    logic [59:0] rx_sum;
    logic [59:0] ry_sum;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [30:0] pos_z;

    // config channel
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg        <= CENTER_X_RST;
            center_y_reg        <= CENTER_Y_RST;
            inv_depth_scale_reg <= INV_DEPTH_SCALE_RST;
            inv_focal_x_reg     <= INV_FOCAL_X_RST;
            inv_focal_y_reg     <= INV_FOCAL_Y_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_CENTER_X:        center_x_reg        <= cfg_data[15:0];
                REG_CENTER_Y:        center_y_reg        <= cfg_data[15:0];
                REG_INV_DEPTH_SCALE: inv_depth_scale_reg <= cfg_data;
                REG_INV_FOCAL_X:     inv_focal_x_reg     <= cfg_data;
                REG_INV_FOCAL_Y:     inv_focal_y_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage advance chain
    assign adv4          = !out_v_reg || m_axis_tready;
    assign adv3          = !s3_v_reg || adv4;
    assign adv2          = !s2_v_reg || adv3;
    assign adv1          = !s1_v_reg || adv2;
    assign s_axis_tready = adv1;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // stage 1: offsets and first multiplies
    always_comb
    begin
        in_column = s_axis_tdata[11:0];
        in_row    = s_axis_tdata[23:12];
        in_depth  = s_axis_tdata[39:24];
        keep      = (in_depth != 16'd0) && ({2'b00, in_column} < COL_LIMIT)
                    && ({2'b00, in_row} < ROW_LIMIT);
        px_col    = {in_column, 4'b0000};
        px_row    = {in_row, 4'b0000};
        neg_x     = center_x_reg > px_col;
        neg_y     = center_y_reg > px_row;
        mag_x     = neg_x ? (center_x_reg - px_col) : (px_col - center_x_reg);
        mag_y     = neg_y ? (center_y_reg - px_row) : (px_row - center_y_reg);
        s1_next.zf    = {24'd0, in_depth} * {16'd0, inv_depth_scale_reg};
        s1_next.mx    = {24'd0, mag_x} * {16'd0, inv_focal_x_reg};
        s1_next.my    = {24'd0, mag_y} * {16'd0, inv_focal_y_reg};
        s1_next.neg_x = neg_x;
        s1_next.neg_y = neg_y;
        s1_next.color = s_axis_tdata[63:40];
    end

    // stage 2: rounding to q16.16 depth and q.16 scale
    always_comb
    begin
        zf_rnd        = s1_reg.zf + 40'd128;
        mx_rnd        = s1_reg.mx + 40'd2048;
        my_rnd        = s1_reg.my + 40'd2048;
        s2_next.zr    = zf_rnd[39:8];
        s2_next.tx    = mx_rnd[39:12];
        s2_next.ty    = my_rnd[39:12];
        s2_next.neg_x = s1_reg.neg_x;
        s2_next.neg_y = s1_reg.neg_y;
        s2_next.color = s1_reg.color;
    end

    // stage 3: lateral products
    always_comb
    begin
        s3_next.px    = {32'd0, s2_reg.tx} * {28'd0, s2_reg.zr};
        s3_next.py    = {32'd0, s2_reg.ty} * {28'd0, s2_reg.zr};
        s3_next.zr    = s2_reg.zr;
        s3_next.neg_x = s2_reg.neg_x;
        s3_next.neg_y = s2_reg.neg_y;
        s3_next.color = s2_reg.color;
    end

    // stage 4: round, sign and saturate
    always_comb
    begin
        rx_sum   = s3_reg.px + 60'd32768;
        ry_sum   = s3_reg.py + 60'd32768;
        pos_x    = sat_lat(rx_sum[59:16], s3_reg.neg_x);
        pos_y    = sat_lat(ry_sum[59:16], s3_reg.neg_y);
        pos_z    = (s3_reg.zr > Z_MAX) ? Z_MAX[30:0] : s3_reg.zr[30:0];
        out_next = {1'b0, s3_reg.color, pos_z, pos_y, pos_x};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_v_reg <= in_accept && keep;
            end
            if (adv2)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (adv3)
            begin
                s3_v_reg <= s2_v_reg;
            end
            if (adv4)
            begin
                out_v_reg <= s3_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_reg <= s1_next;
        end
        if (adv2)
        begin
            s2_reg <= s2_next;
        end
        if (adv3)
        begin
            s3_reg <= s3_next;
        end
        if (adv4)
        begin
            out_reg <= out_next;
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = out_reg;

`ifndef ASSERT_OFF
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled while output register is empty");

    a_zero_depth_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tdata[39:24] == 16'd0)) |=> !s1_v_reg)
        else $error("zero depth pixel entered the pipeline");

    a_last_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_v_reg && !out_v_reg) |=> out_v_reg)
        else $error("last stage did not move into empty output register");
`endif

endmodule

`default_nettype wire

FILE: test/tb_depth_pixel_backprojection_unit.sv
// tb_depth_pixel_backprojection_unit: self-checking bench for the rgb-d pixel
// back-projection unit, random stream stalls on both sides plus register changes
// between drained phases; uses dpb_pkg and depth_pixel_backprojection_unit
`default_nettype none

module tb_depth_pixel_backprojection_unit;

    import dpb_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 12;

    // column, row, depth_raw, blue, green, red from the lowest bit up
    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] depth;
        logic [11:0] row;
        logic [11:0] column;
    } pixel_t;

    // pos_x, pos_y, pos_z, blue, green, red, pad from the lowest bit up
    typedef struct packed {
        logic        pad;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [30:0] pos_z;
        logic [31:0] pos_y;
        logic [31:0] pos_x;
    } point_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // camera registers as the bench believes them
    logic [15:0] cam_cx = CENTER_X_RST;
    logic [15:0] cam_cy = CENTER_Y_RST;
    logic [23:0] depth_gain = INV_DEPTH_SCALE_RST;
    logic [23:0] focal_gain_x = INV_FOCAL_X_RST;
    logic [23:0] focal_gain_y = INV_FOCAL_Y_RST;

    pixel_t pixels_pending[$];
    point_t points_due[$];
    int     mismatches = 0;
    int     cycles = 0;
    logic   in_taken = 1'b0;
    logic   out_taken = 1'b0;
    int     src_gap = 0;
    int     src_burst = 0;
    int     snk_gap = 0;
    int     snk_burst = 0;

    depth_pixel_backprojection_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // lateral coordinate, rounding on the magnitude and saturating to q16.16
    function automatic logic [31:0] lateral_coord(logic [11:0] pix, logic [15:0] centre,
                                                  logic [23:0] gain, logic [63:0] zr);
        logic [63:0] pos;
        logic [63:0] mag;
        logic [63:0] t;
        logic [63:0] r;
        logic        neg;
        pos = {48'd0, pix, 4'd0};
        neg = {48'd0, centre} > pos;
        mag = neg ? {48'd0, centre} - pos : pos - {48'd0, centre};
        t = (mag * {40'd0, gain} + 64'd2048) >> 12;
        r = (t * zr + 64'd32768) >> 16;
        if (neg)
        begin
            if (r > 64'h8000_0000)
                r = 64'h8000_0000;
            return 32'd0 - r[31:0];
        end
        if (r > 64'h7FFF_FFFF)
            r = 64'h7FFF_FFFF;
        return r[31:0];
    endfunction

    function automatic point_t back_project(pixel_t px);
        point_t      pt;
        logic [63:0] zr;
        zr = ({48'd0, px.depth} * {40'd0, depth_gain} + 64'd128) >> 8;
        pt.pad   = 1'b0;
        pt.pos_x = lateral_coord(px.column, cam_cx, focal_gain_x, zr);
        pt.pos_y = lateral_coord(px.row, cam_cy, focal_gain_y, zr);
        pt.pos_z = (zr > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : zr[30:0];
        pt.blue  = px.blue;
        pt.green = px.green;
        pt.red   = px.red;
        return pt;
    endfunction

    // handshake sampling, prediction and checking
    always @(posedge clk)
    begin : monitor
        pixel_t px;
        point_t got;
        point_t want;
        if (!rst_n)
        begin
            in_taken  <= 1'b0;
            out_taken <= 1'b0;
        end
        else
        begin
            in_taken  <= s_axis_tvalid && s_axis_tready;
            out_taken <= m_axis_tvalid && m_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
            begin
                px = pixel_t'(s_axis_tdata);
                if (px.depth != 16'd0 && px.column < MAX_COLUMNS && px.row < MAX_ROWS)
                    points_due = {points_due, back_project(px)};
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = point_t'(m_axis_tdata);
                if (points_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word x=%h y=%h z=%h rgb=%h%h%h",
                                 got.pos_x, got.pos_y, got.pos_z,
                                 got.red, got.green, got.blue);
                end
                else
                begin
                    want = points_due.pop_front();
                    if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
                        got.pos_z !== want.pos_z || got.blue !== want.blue ||
                        got.green !== want.green || got.red !== want.red ||
                        got.pad !== want.pad)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp x=%h y=%h z=%h rgb=%h%h%h pad=%b",
                                     want.pos_x, want.pos_y, want.pos_z, want.red,
                                     want.green, want.blue, want.pad,
                                     " got x=%h y=%h z=%h rgb=%h%h%h pad=%b",
                                     got.pos_x, got.pos_y, got.pos_z, got.red,
                                     got.green, got.blue, got.pad);
                    end
                end
            end
        end
    end

    function automatic int draw_wait(inout int burst);
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            burst = $urandom_range(20, 40);
        return $urandom_range(0, 14);
    endfunction

    // pixel source
    always @(negedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || in_taken)
        begin
            if (in_taken)
                src_gap = draw_wait(src_burst);
            if (src_gap > 0)
            begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pixels_pending.size() > 0)
            begin
                s_axis_tdata  <= pixels_pending.pop_front();
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // point sink
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (out_taken)
                snk_gap = draw_wait(snk_burst);
            if (snk_gap > 0)
            begin
                snk_gap--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_CENTER_X:        cam_cx = value[15:0];
            REG_CENTER_Y:        cam_cy = value[15:0];
            REG_INV_DEPTH_SCALE: depth_gain = value;
            REG_INV_FOCAL_X:     focal_gain_x = value;
            REG_INV_FOCAL_Y:     focal_gain_y = value;
            default:             ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_camera(logic [23:0] cx, logic [23:0] cy, logic [23:0] zs,
                                logic [23:0] fx, logic [23:0] fy);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_INV_DEPTH_SCALE, zs);
        write_reg(REG_INV_FOCAL_X, fx);
        write_reg(REG_INV_FOCAL_Y, fy);
    endtask

    // wait until the stream is empty and all predicted points have come out, then let the pipe idle
    task automatic settle();
        while (pixels_pending.size() > 0 || s_axis_tvalid || points_due.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic add_pixel(int col, int row, int depth, int b, int g, int r);
        pixel_t px;
        px.column = 12'(col);
        px.row    = 12'(row);
        px.depth  = 16'(depth);
        px.blue   = 8'(b);
        px.green  = 8'(g);
        px.red    = 8'(r);
        pixels_pending = {pixels_pending, px};
    endtask

    task automatic add_random_pixels(int n);
        int col;
        int row;
        int depth;
        repeat (n)
        begin
            col = $urandom_range(0, 4095);
            row = $urandom_range(0, 4095);
            case ($urandom_range(0, 15))
                0:       depth = 0;
                1:       depth = 65535;
                2:       depth = 1;
                default: depth = $urandom_range(0, 65535);
            endcase
            if ($urandom_range(0, 15) == 0)
                col = ($urandom_range(0, 1) == 0) ? 0 : 4095;
            if ($urandom_range(0, 15) == 0)
                row = ($urandom_range(0, 1) == 0) ? 0 : 4095;
            add_pixel(col, row, depth, $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255));
        end
    endtask

    task automatic random_camera();
        if ($urandom_range(0, 5) == 0)
            write_camera($urandom_range(0, 1) ? 24'hFFFFFF : 24'd0,
                         $urandom_range(0, 1) ? 24'hFFFFFF : 24'd0,
                         $urandom_range(0, 1) ? 24'hFFFFFF : 24'd0,
                         $urandom_range(0, 1) ? 24'hFFFFFF : 24'd0,
                         $urandom_range(0, 1) ? 24'hFFFFFF : 24'd0);
        else
            write_camera(24'($urandom_range(0, 24'hFFFFFF)),
                         24'($urandom_range(0, 24'hFFFFFF)),
                         24'($urandom_range(1 << 8, 1 << 18)),
                         24'($urandom_range(1 << 10, 1 << 17)),
                         24'($urandom_range(1 << 10, 1 << 17)));
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_IDX_W'($urandom_range(5, 7)), 24'($urandom_range(0, 24'hFFFFFF)));
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset camera, field extremes, missing depth
        add_pixel(0, 0, 1, 0, 0, 0);
        add_pixel(4095, 4095, 65535, 255, 255, 255);
        add_pixel(4095, 0, 0, 85, 170, 15);
        add_pixel(0, 4095, 32768, 240, 15, 170);
        add_pixel(325, 253, 1000, 1, 2, 3);
        settle();

        // all registers at their top, centers masked to 16 bits, negative saturation
        write_camera(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        add_pixel(0, 0, 65535, 255, 0, 255);
        add_pixel(4095, 4095, 65535, 0, 255, 0);
        add_pixel(2048, 100, 1, 12, 34, 56);
        settle();

        // centers at zero, positive saturation
        write_reg(REG_CENTER_X, 24'hFF0000);
        write_reg(REG_CENTER_Y, 24'd0);
        add_pixel(4095, 4095, 65535, 9, 9, 9);
        add_pixel(1, 1, 1, 200, 100, 50);
        settle();

        // zero reciprocals, unknown register indexes ignored
        write_camera(24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
        write_reg(3'd5, 24'h123456);
        write_reg(3'd6, 24'hFFFFFF);
        write_reg(3'd7, 24'hABCDEF);
        add_pixel(4095, 0, 65535, 77, 88, 99);
        add_pixel(0, 4095, 1, 1, 1, 1);
        settle();

        // pixel on the principal point, one axis zero reciprocal
        write_camera(24'd1600, 24'd1600, 24'd65536, 24'd40000, 24'd0);
        add_pixel(100, 100, 5000, 10, 20, 30);
        add_pixel(100, 3000, 65535, 40, 50, 60);
        add_pixel(3000, 100, 777, 70, 80, 90);
        add_pixel(99, 101, 2, 100, 110, 120);
        settle();

        // back to reset values
        write_camera(24'(CENTER_X_RST), 24'(CENTER_Y_RST), INV_DEPTH_SCALE_RST,
                     INV_FOCAL_X_RST, INV_FOCAL_Y_RST);
        add_random_pixels(50);
        settle();

        repeat (7)
        begin
            random_camera();
            add_random_pixels(25);
            settle();
            add_random_pixels(25);
            settle();
        end

        while (pixels_pending.size() > 0 || s_axis_tvalid || points_due.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
